// ===== sv/arh_pkg.sv =====
// Package for the eight-lane AES-round hash: types, constants and round functions.
// Used by arh_ctrl, arh_dp and aes_round_eight_lane_hash.
package arh_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 128;
  localparam int unsigned NUM_LANES = 8;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] LEN_POS = 7'd120;

  typedef enum logic [0:0] {
    CFG_SEED_LOW  = 1'b0,
    CFG_SEED_HIGH = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_PAD,
    ST_FINAL,
    ST_FOLD,
    ST_OUT_LO,
    ST_OUT_HI
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       take_word;   // merge accepted word into buffer
    logic       round_blk;   // run block round on lane rnd_lane
    logic       round_fin;   // run finish round on lane rnd_lane
    logic       round_fold;  // fold lane rnd_lane into hash
    logic [2:0] rnd_lane;
    logic       pad_start;   // write 0x80 at current position
    logic       pad_zero;    // write zero word at pad_word
    logic       pad_len;     // write length into the last buffer word
    logic [3:0] pad_word;
    logic       reload;      // reload lanes, clear counters
    logic       hash_clr;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [6:0] fill;        // buffered bytes
  } sts_t;

  localparam logic [63:0] LANE_CONST [16] = '{
    64'hc05bbd6b47c57574, 64'hf83c1e9e4a934534,
    64'ha224e4507e645d91, 64'he7a9131a4b842813,
    64'h58f082e3580f347e, 64'hceb5795349196aff,
    64'hb549200b5168588f, 64'hfd5c07200540ada5,
    64'h526b8e90108029d5, 64'h46e634784c1350f0,
    64'h4e9a8c21921fc259, 64'h8f5d6730b44e65c3,
    64'hac0120817de73b56, 64'ha5be99de5ff769dd,
    64'h7541811329b4609f, 64'h4c4cfa866064ec93
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // one AES encryption round: ShiftRows, SubBytes, MixColumns, key XOR
  function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] key);
    logic [7:0] t [16];
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[st[8*(r + 4*((c + r) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      o[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    aes_round = o ^ key;
  endfunction

endpackage

// ===== sv/aes_round_eight_lane_hash.sv =====
// Eight-lane AES-round hash, top level.
// A word that fills no block is merged into the buffer; a full block adds block rounds
// (one shared AES round unit, one lane a cycle). The final word adds padding writes
// (over one pad block, or two when a second one is needed), 32 finish rounds and
// 8 fold rounds, then the two result words. One word at a time; seed writes are taken
// only while idle with no input pending; sync active-low reset loads lanes from
// constants and a zero seed.
module aes_round_eight_lane_hash #(
  parameter int unsigned BLOCK_BYTES = arh_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // data_word[63:0], byte_count[67:64], zero pad
  input  logic        in_tlast,   // message_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // hash_word
  output logic        out_tlast,  // final_word
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import arh_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_rdy, out_vld, out_hi, in_fire, out_fire, cfg_fire;
  logic [127:0] hash;

  assign in_tready = in_rdy;
  assign in_fire = in_tvalid && in_rdy;
  assign out_tvalid = out_vld;
  assign out_fire = out_vld && out_tready;
  assign out_tlast = out_hi;
  assign out_tdata = out_hi ? hash[127:64] : hash[63:0];
  assign cfg_ready = in_rdy && !in_tvalid;
  assign cfg_fire = cfg_valid && cfg_ready;

  arh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .byte_count(in_tdata[67:64]),
    .message_end(in_tlast), .out_fire(out_fire), .sts(sts), .cmd(cmd),
    .in_rdy(in_rdy), .out_vld(out_vld), .out_hi(out_hi)
  );

  arh_dp #(.BLOCK_BYTES(BLOCK_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .data_word(in_tdata[63:0]),
    .byte_count(in_tdata[67:64]), .cfg_wr(cfg_fire), .cfg_idx(cfg_index),
    .cfg_data(cfg_data), .hash(hash)
  );
endmodule

// ===== sv/arh_dp.sv =====
// Datapath of the eight-lane AES-round hash: block buffer, lanes, shared round unit.
// Depends on arh_pkg; driven by arh_ctrl through cmd_t.
module arh_dp #(
  parameter int unsigned BLOCK_BYTES = arh_pkg::BLOCK_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  arh_pkg::cmd_t  cmd,
  output arh_pkg::sts_t  sts,
  input  logic [63:0]    data_word,
  input  logic [3:0]     byte_count,
  input  logic           cfg_wr,
  input  logic [0:0]     cfg_idx,
  input  logic [63:0]    cfg_data,
  output logic [127:0]   hash
);
  import arh_pkg::*;

  localparam int unsigned WORDS = BLOCK_BYTES / 8;
  localparam int unsigned PW = $clog2(BLOCK_BYTES);
  localparam int unsigned WW = $clog2(WORDS);

  logic [63:0]  seed_lo_r, seed_hi_r;
  logic [127:0] lane_r [NUM_LANES];
  logic [63:0]  buf_r [WORDS];
  logic [63:0]  spill_r;   // bytes past the block end, moved to word 0 on the lane 7 block round
  logic [PW-1:0] fill_r;
  logic [63:0]  len_r;
  logic [127:0] hash_r;

  logic [3:0]   n;
  logic [127:0] blk_key, st_in, key_in, rnd_out;
  logic [127:0] buf_pair;
  logic [PW:0]  fill_sum;
  logic [WW-1:0] wsel;
  logic [2:0]   boff;
  logic [127:0] mrg;       // word pair holding spill of merge
  logic [127:0] mrg_mask;

  assign n = (byte_count > 4'd8) ? 4'd8 : byte_count;
  assign sts.fill = fill_r;
  assign hash = hash_r;
  assign wsel = fill_r[PW-1:3];
  assign boff = fill_r[2:0];
  assign fill_sum = {1'b0, fill_r} + {{(PW-3){1'b0}}, n};

  // byte-shifted merge window over two consecutive words
  always_comb begin
    logic [127:0] dm;
    dm = {64'd0, data_word};
    mrg_mask = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) mrg_mask[8*b +: 8] = 8'hff;
    end
    mrg = dm << {boff, 3'b000};
    mrg_mask = mrg_mask << {boff, 3'b000};
  end

  // shared round unit operand selection
  always_comb begin
    buf_pair = {buf_r[{cmd.rnd_lane, 1'b1}], buf_r[{cmd.rnd_lane, 1'b0}]};
    blk_key = buf_pair;
    st_in = lane_r[cmd.rnd_lane];
    key_in = blk_key;
    if (cmd.round_fin) begin
      key_in = {LANE_CONST[{cmd.rnd_lane, 1'b1}], LANE_CONST[{cmd.rnd_lane, 1'b0}]};
    end else if (cmd.round_fold) begin
      st_in = hash_r;
      key_in = lane_r[cmd.rnd_lane];
    end
    rnd_out = aes_round(st_in, key_in);
  end

  // seed registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_lo_r <= '0;
      seed_hi_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_idx == CFG_SEED_LOW) seed_lo_r <= cfg_data;
      else seed_hi_r <= cfg_data;
    end
  end

  // lanes, counters and hash accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        lane_r[i] <= {LANE_CONST[2*i+1], LANE_CONST[2*i]};
      end
      fill_r <= '0;
      len_r <= '0;
      hash_r <= '0;
    end else begin
      if (cfg_wr || cmd.reload) begin
        for (int i = 0; i < NUM_LANES; i++) begin
          lane_r[i] <= {LANE_CONST[2*i+1] ^ ((cfg_wr && cfg_idx == CFG_SEED_HIGH) ?
                        cfg_data : seed_hi_r),
                        LANE_CONST[2*i] ^ ((cfg_wr && cfg_idx == CFG_SEED_LOW) ?
                        cfg_data : seed_lo_r)};
        end
        fill_r <= '0;
        len_r <= '0;
      end else if (cmd.round_blk || cmd.round_fin) begin
        lane_r[cmd.rnd_lane] <= rnd_out;
      end
      if (cmd.round_fold) hash_r <= rnd_out;
      if (cmd.hash_clr) hash_r <= '0;
      if (cmd.take_word) begin
        fill_r <= fill_sum[PW-1:0];
        len_r <= len_r + {60'd0, n};
      end
      if (cmd.pad_start) fill_r <= '0;
    end
  end

  // block buffer, written only, no reset
  // a spill past the last word goes to word 0 once the block round has read it
  always_ff @(posedge clk) begin
    if (cmd.take_word) begin
      buf_r[wsel] <= (buf_r[wsel] & ~mrg_mask[63:0]) | (mrg[63:0] & mrg_mask[63:0]);
      if (wsel == WW'(WORDS - 1)) begin
        spill_r <= mrg[127:64];
      end else if (mrg_mask[127:64] != '0) begin
        buf_r[WW'(wsel + 1'b1)] <= mrg[127:64];
      end
    end else if (cmd.round_blk && cmd.rnd_lane == 3'd7) begin
      buf_r[{WW{1'b0}}] <= spill_r;
    end else if (cmd.pad_start) begin
      buf_r[wsel] <= (buf_r[wsel] & ((64'd1 << {boff, 3'b000}) - 64'd1)) |
                     ({56'd0, PAD_BYTE} << {boff, 3'b000});
    end else if (cmd.pad_zero) begin
      buf_r[cmd.pad_word[WW-1:0]] <= '0;
    end else if (cmd.pad_len) begin
      buf_r[WW'(WORDS - 1)] <= len_r;
    end
  end
endmodule

// ===== sv/arh_ctrl.sv =====
// Controller of the eight-lane AES-round hash: sequences absorb, padding, rounds, output.
// Depends on arh_pkg; commands arh_dp through cmd_t.
module arh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [3:0]    byte_count,
  input  logic          message_end,
  input  logic          out_fire,
  input  arh_pkg::sts_t sts,
  output arh_pkg::cmd_t cmd,
  output logic          in_rdy,
  output logic          out_vld,
  output logic          out_hi
);
  import arh_pkg::*;

  state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;     // lane / word / round counter
  logic       end_r, end_nxt;     // message end seen, marker not yet written
  logic       pad2_r, pad2_nxt;   // second padding block pending
  logic [3:0] n;
  logic [7:0] tot;

  assign n = (byte_count > 4'd8) ? 4'd8 : byte_count;
  assign tot = {1'b0, sts.fill} + {4'd0, n};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      end_r <= 1'b0;
      pad2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      end_r <= end_nxt;
      pad2_r <= pad2_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    end_nxt = end_r;
    pad2_nxt = pad2_r;
    cmd = '0;
    cmd.rnd_lane = cnt_r[2:0];
    cmd.pad_word = cnt_r[3:0];
    in_rdy = 1'b0;
    out_vld = 1'b0;
    out_hi = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.take_word = 1'b1;
          end_nxt = message_end;
          cnt_nxt = '0;
          if (tot[7]) state_nxt = ST_ABSORB;
          else if (message_end) begin
            state_nxt = ST_PAD;
            cnt_nxt = 5'(tot[6:3]) + ((tot[2:0] != 3'd0) ? 5'd1 : 5'd0);
            pad2_nxt = (tot[6:0] >= LEN_POS);
          end
        end
      end
      // one lane per cycle for a full block; counts from 16 on padding blocks
      ST_ABSORB: begin
        cmd.round_blk = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r[2:0] == 3'd7) begin
          cnt_nxt = '0;
          if (pad2_r) begin
            pad2_nxt = 1'b0;
            state_nxt = ST_PAD;
          end else if (cnt_r[4]) begin
            state_nxt = ST_FINAL;
          end else if (end_r) begin
            state_nxt = ST_PAD;
            cnt_nxt = {1'b0, sts.fill[6:3]} + ((sts.fill[2:0] != 3'd0) ? 5'd1 : 5'd0);
            pad2_nxt = (sts.fill >= LEN_POS);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      // first pass writes marker; later passes zero words, then length unless a second pad block is pending
      ST_PAD: begin
        if (!cnt_r[4] && !end_r) begin
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r[3:0] == 4'd15) begin
            cmd.pad_len = !pad2_r;
            state_nxt = ST_ABSORB;
            cnt_nxt = 5'd16;
          end else begin
            cmd.pad_zero = 1'b1;
          end
        end else begin
          cmd.pad_start = 1'b1;
          end_nxt = 1'b0;
          cnt_nxt = {1'b0, sts.fill[6:3]} + 5'd1;
          if (sts.fill[6:3] == 4'd15) begin
            cmd.pad_len = 1'b0;
            state_nxt = ST_ABSORB;
            cnt_nxt = 5'd16;
          end
        end
      end
      // four rounds per lane with lane constants
      ST_FINAL: begin
        cmd.round_fin = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          cnt_nxt = '0;
          cmd.hash_clr = 1'b1;
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.round_fold = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r[2:0] == 3'd7) begin
          state_nxt = ST_OUT_LO;
          cmd.reload = 1'b1;
        end
      end
      ST_OUT_LO: begin
        out_vld = 1'b1;
        if (out_fire) state_nxt = ST_OUT_HI;
      end
      ST_OUT_HI: begin
        out_vld = 1'b1;
        out_hi = 1'b1;
        if (out_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
